/* hw/rtl/oli_pkg.sv */
// ----------------------------------------------------------------------------
// oli_pkg
// Shared types and constants for the ordered list block: item structs,
// operation and status codes, cell control codes.
// ----------------------------------------------------------------------------
package oli_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = 5;
	localparam int POS_W      = $clog2(CAPACITY);

	localparam logic [2:0] OP_APPEND      = 3'd0;
	localparam logic [2:0] OP_INSERT      = 3'd1;
	localparam logic [2:0] OP_REMOVE_AT   = 3'd2;
	localparam logic [2:0] OP_REMOVE_ITEM = 3'd3;
	localparam logic [2:0] OP_CLEAR       = 3'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_RANGE    = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_PREV = 2'd2,
		CELL_NEXT = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic        [2:0]  op;
		logic        [4:0]  index;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] removed_value;
		logic        [4:0]  element_count;
	} rsp_item_t;

endpackage

/* hw/rtl/oli_cell.sv */
// ----------------------------------------------------------------------------
// oli_cell
// One list entry. Holds, loads the key, or takes the word of either
// neighbor; flags a match of its word against the key.
// ----------------------------------------------------------------------------
module oli_cell (
	input  logic                            clk,
	input  oli_pkg::cell_op_t               ctrl,
	input  logic [oli_pkg::DATA_WIDTH-1:0]  key,
	input  logic [oli_pkg::DATA_WIDTH-1:0]  prev_word,
	input  logic [oli_pkg::DATA_WIDTH-1:0]  next_word,
	output logic [oli_pkg::DATA_WIDTH-1:0]  word,
	output logic                            match
);

	logic [oli_pkg::DATA_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		case (ctrl)
			oli_pkg::CELL_LOAD: word_q <= key;
			oli_pkg::CELL_PREV: word_q <= prev_word;
			oli_pkg::CELL_NEXT: word_q <= next_word;
			default:            word_q <= word_q;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

/* hw/rtl/ordered_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// Fixed-capacity ordered list of signed words with append, insert, remove-at,
// remove-first-match and clear.
// ----------------------------------------------------------------------------
// The accept edge registers the request; the EXEC state then applies it across
// the row of entry cells (all entries compare against the key and shift
// toward their neighbors in parallel) while the result goes into the output
// register. A new item is taken only once the block is back in idle, so it
// never takes a new item before the last one is through; the apply step
// waits while a previous result sits stalled in the output register.
module ordered_list_insert_remove (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  oli_pkg::req_item_t req_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output oli_pkg::rsp_item_t rsp_item
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	localparam int N = oli_pkg::CAPACITY;
	localparam int W = oli_pkg::DATA_WIDTH;
	localparam int C = oli_pkg::CNT_W;

	state_t                state_q;
	logic [C-1:0]          count_q;
	logic [2:0]            op_q;
	logic [4:0]            index_q;
	logic [W-1:0]          key_q;
	logic                  rsp_valid_q;
	oli_pkg::rsp_item_t    rsp_item_q;

	logic [W-1:0]          cell_word [N];
	logic [N-1:0]          cell_match;
	oli_pkg::cell_op_t     cell_ctrl [N];

	logic                  fire;
	logic [N-1:0]          hit;
	logic [N-1:0]          first_hit;
	logic [C-1:0]          hit_pos;
	logic                  do_ins;
	logic                  do_rem;
	logic [C-1:0]          at_pos;
	logic [1:0]            status;
	logic [C-1:0]          next_count;
	logic [W-1:0]          removed;

	assign fire      = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		hit = '0;
		for (int k = 0; k < N; k++) begin
			hit[k] = cell_match[k] && (C'(k) < count_q);
		end
		first_hit = hit & (~hit + N'(1));
		hit_pos   = '0;
		for (int k = 0; k < N; k++) begin
			if (first_hit[k]) begin
				hit_pos = hit_pos | C'(k);
			end
		end
	end

	always_comb begin
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		at_pos     = index_q;
		status     = oli_pkg::STATUS_OK;
		next_count = count_q;
		case (op_q)
			oli_pkg::OP_APPEND: begin
				at_pos = count_q;
				if (count_q >= C'(N)) status = oli_pkg::STATUS_FULL;
				else                  do_ins = 1'b1;
			end
			oli_pkg::OP_INSERT: begin
				if (index_q > count_q)     status = oli_pkg::STATUS_RANGE;
				else if (count_q >= C'(N)) status = oli_pkg::STATUS_FULL;
				else                       do_ins = 1'b1;
			end
			oli_pkg::OP_REMOVE_AT: begin
				if (index_q >= count_q) status = oli_pkg::STATUS_RANGE;
				else                    do_rem = 1'b1;
			end
			oli_pkg::OP_REMOVE_ITEM: begin
				at_pos = hit_pos;
				if (hit == '0) status = oli_pkg::STATUS_NOTFOUND;
				else           do_rem = 1'b1;
			end
			oli_pkg::OP_CLEAR: next_count = '0;
			default: ;
		endcase
		if (do_ins) next_count = count_q + C'(1);
		if (do_rem) next_count = count_q - C'(1);
		removed = do_rem ? cell_word[at_pos[oli_pkg::POS_W-1:0]] : '0;
	end

	always_comb begin
		for (int k = 0; k < N; k++) begin
			cell_ctrl[k] = oli_pkg::CELL_HOLD;
			if (fire && do_ins) begin
				if (C'(k) == at_pos)
					cell_ctrl[k] = oli_pkg::CELL_LOAD;
				else if (C'(k) > at_pos && C'(k) <= count_q)
					cell_ctrl[k] = oli_pkg::CELL_PREV;
			end else if (fire && do_rem) begin
				if (C'(k) >= at_pos && (C'(k) + C'(1)) < count_q)
					cell_ctrl[k] = oli_pkg::CELL_NEXT;
			end
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [W-1:0] prev_w;
		logic [W-1:0] next_w;
		if (g == 0) begin : g_first
			assign prev_w = key_q;
		end else begin : g_mid
			assign prev_w = cell_word[g-1];
		end
		if (g == N - 1) begin : g_last
			assign next_w = key_q;
		end else begin : g_inner
			assign next_w = cell_word[g+1];
		end
		oli_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl[g]),
			.key       (key_q),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[g]),
			.match     (cell_match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req_valid) state_q <= ST_EXEC;
				ST_EXEC: if (fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (fire) begin
				count_q     <= next_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp_stall == 1'b0) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_q    <= req_item.op;
			index_q <= req_item.index;
			key_q   <= req_item.value[W-1:0];
		end
		if (fire) begin
			rsp_item_q.status        <= status;
			rsp_item_q.removed_value <= 32'(removed);
			rsp_item_q.element_count <= next_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= C'(N))
		else $error("entry count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_ins) |=> (count_q == $past(count_q) + C'(1)))
		else $error("insert did not grow the list");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_rem) |=> (count_q == $past(count_q) - C'(1)))
		else $error("remove did not shrink the list");

	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status != oli_pkg::STATUS_OK) |=> $stable(count_q))
		else $error("failed operation changed the count");

endmodule

/* dv/list_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_check_pkg
// Scoreboard for the ordered list block. It keeps its own copy of the list
// and the entry count, works out the result of every accepted request item
// and checks each response item against the oldest result still waiting.
// ----------------------------------------------------------------------------
package list_check_pkg;

	import oli_pkg::*;

	class list_scoreboard;
		logic [DATA_WIDTH-1:0] entries [CAPACITY];
		int unsigned           held;
		rsp_item_t             expected_q [$];
		int unsigned           errors;
		int unsigned           requests;
		int unsigned           responses;
		int unsigned           status_seen [4];

		function new();
			held      = 0;
			errors    = 0;
			requests  = 0;
			responses = 0;
			foreach (status_seen[k]) begin
				status_seen[k] = 0;
			end
		endfunction

		// take out one entry and close the gap
		function logic [DATA_WIDTH-1:0] take_entry(int unsigned pos);
			logic [DATA_WIDTH-1:0] word;
			word = entries[POS_W'(pos)];
			for (int unsigned k = pos; k + 1 < held; k++) begin
				entries[POS_W'(k)] = entries[POS_W'(k + 1)];
			end
			held--;
			return word;
		endfunction

		function void note_request(req_item_t req);
			rsp_item_t r;
			int        hit;
			r.status        = STATUS_OK;
			r.removed_value = '0;
			hit             = -1;
			case (req.op)
				OP_APPEND: begin
					if (held >= CAPACITY) begin
						r.status = STATUS_FULL;
					end else begin
						entries[POS_W'(held)] = req.value;
						held++;
					end
				end
				OP_INSERT: begin
					if (req.index > held) begin
						r.status = STATUS_RANGE;
					end else if (held >= CAPACITY) begin
						r.status = STATUS_FULL;
					end else begin
						for (int unsigned k = held; k > req.index; k--) begin
							entries[POS_W'(k)] = entries[POS_W'(k - 1)];
						end
						entries[POS_W'(req.index)] = req.value;
						held++;
					end
				end
				OP_REMOVE_AT: begin
					if (req.index >= held) begin
						r.status = STATUS_RANGE;
					end else begin
						r.removed_value = take_entry(req.index);
					end
				end
				OP_REMOVE_ITEM: begin
					for (int k = 0; k < held; k++) begin
						if (hit < 0 && entries[POS_W'(k)] == req.value) begin
							hit = k;
						end
					end
					if (hit < 0) begin
						r.status = STATUS_NOTFOUND;
					end else begin
						r.removed_value = take_entry(hit);
					end
				end
				OP_CLEAR: begin
					held = 0;
				end
				default: begin
				end
			endcase
			r.element_count = CNT_W'(held);
			status_seen[r.status]++;
			requests++;
			expected_q.push_back(r);
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			responses++;
			if (expected_q.size() == 0) begin
				$error("response item with no request pending");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.removed_value !== want.removed_value) begin
				$error("removed_value: expected %0d, actual %0d",
					want.removed_value, got.removed_value);
				errors++;
			end
			if (got.element_count !== want.element_count) begin
				$error("element_count: expected %0d, actual %0d",
					want.element_count, got.element_count);
				errors++;
			end
		endfunction
	endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ordered_list_insert_remove with a directed opening (empty, full,
// bad index, duplicate match, unused op codes) and then random operations
// that fill and drain the list, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

	import oli_pkg::*;
	import list_check_pkg::*;

	localparam int RANDOM_ITEMS = 1215;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 120;
	localparam int PAUSE_AT     = 800;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 20;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_item_t req_item;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp_item;

	list_scoreboard board;
	int unsigned    idle_cycles = 0;
	bit             filling;

	ordered_list_insert_remove uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic req_item_t make_req(logic [2:0] op, logic [4:0] index,
		logic [31:0] value);
		req_item_t r;
		r.op    = op;
		r.index = index;
		r.value = value;
		return r;
	endfunction

	task automatic send(req_item_t item, int unsigned gap);
		req_valid <= 1'b1;
		req_item  <= item;
		do @(posedge clk); while (req_stall);
		board.note_request(item);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 7))
				0:       return 32'h8000_0000;
				1:       return 32'h7FFF_FFFF;
				2:       return 32'hFFFF_FFFF;
				3:       return 32'h0000_0000;
				4:       return 32'h0000_0001;
				5:       return 32'h5A5A_5A5A;
				6:       return 32'hA5A5_A5A5;
				default: return 32'h0001_0000;
			endcase
		end
		return $urandom;
	endfunction

	function automatic req_item_t random_req();
		req_item_t   r;
		int unsigned roll;
		int unsigned cnt;
		cnt = board.held;
		if (cnt == CAPACITY && $urandom_range(0, 3) == 0) begin
			filling = 1'b0;
		end else if (cnt == 0 || $urandom_range(0, 49) == 0) begin
			filling = ~filling | (cnt == 0);
		end
		roll    = $urandom_range(0, 99);
		r.index = 5'($urandom_range(0, 31));
		r.value = pick_value();
		if (roll < 2) begin
			r.op = OP_CLEAR + 3'($urandom_range(1, 3));
		end else if (roll < 5) begin
			r.op = OP_CLEAR;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < (filling ? 35 : 15)) begin
				r.op = OP_APPEND;
			end else if (roll < (filling ? 70 : 30)) begin
				r.op = OP_INSERT;
			end else if (roll < (filling ? 85 : 65)) begin
				r.op = OP_REMOVE_AT;
			end else begin
				r.op = OP_REMOVE_ITEM;
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			if (r.op == OP_INSERT) begin
				r.index = 5'($urandom_range(0, cnt));
			end else if (r.op == OP_REMOVE_AT) begin
				r.index = (cnt == 0) ? 5'd0 : 5'($urandom_range(0, cnt - 1));
			end else if (r.op == OP_REMOVE_ITEM && cnt > 0 && $urandom_range(0, 9) < 7) begin
				r.value = board.entries[POS_W'($urandom_range(0, cnt - 1))];
			end
		end
		return r;
	endfunction

	// receiver: response check and stall pattern
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		bit          hold_done;
		logic        stall_next;
		rsp_stall = 1'b0;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				board.check_response(rsp_item);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (!hold_done && board != null && board.requests >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				stall_next = 1'b1;
				hold_left--;
			end else begin
				case (mode)
					0:       stall_next = 1'b0;
					1:       stall_next = ($urandom_range(0, 3) == 0);
					2:       stall_next = ($urandom_range(0, 3) != 0);
					default: stall_next = ~rsp_stall;
				endcase
			end
			rsp_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned burst_left;
		int unsigned gap;
		bit          paused;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_item   = '0;
		filling    = 1'b1;
		burst_left = 0;
		paused     = 1'b0;
		board      = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bad indices, extremes of the value
		send(make_req(OP_REMOVE_AT, 5'd0, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_ITEM, 5'd0, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_INSERT, 5'd1, 32'd5), $urandom_range(0, 2));
		send(make_req(OP_INSERT, 5'd0, 32'h8000_0000), $urandom_range(0, 2));
		send(make_req(OP_APPEND, 5'd31, 32'h7FFF_FFFF), $urandom_range(0, 2));
		send(make_req(OP_INSERT, 5'd1, 32'hFFFF_FFFF), $urandom_range(0, 2));
		send(make_req(OP_INSERT, 5'd3, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_ITEM, 5'd0, 32'h1234_5678), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_ITEM, 5'd0, 32'hFFFF_FFFF), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_AT, 5'd31, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_AT, 5'd2, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_CLEAR + 3'd1, 5'd31, 32'hFFFF_FFFF), $urandom_range(0, 2));
		send(make_req(OP_CLEAR + 3'd2, 5'd16, 32'h8000_0000), $urandom_range(0, 2));
		send(make_req(OP_CLEAR + 3'd3, 5'd0, 32'h7FFF_FFFF), $urandom_range(0, 2));
		send(make_req(OP_CLEAR, 5'd0, 32'd0), $urandom_range(0, 2));
		// fill with duplicates, then full and boundary cases
		for (int k = 0; k < CAPACITY; k++) begin
			send(make_req(OP_INSERT, (k % 2) ? 5'd0 : 5'(k), 32'h55AA_0000 + (k % 4)), 0);
		end
		send(make_req(OP_APPEND, 5'd0, 32'd1), $urandom_range(0, 2));
		send(make_req(OP_INSERT, 5'd16, 32'd1), $urandom_range(0, 2));
		send(make_req(OP_INSERT, 5'd17, 32'd1), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_AT, 5'd16, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_AT, 5'd15, 32'd0), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_ITEM, 5'd0, 32'h55AA_0001), $urandom_range(0, 2));
		send(make_req(OP_REMOVE_AT, 5'd0, 32'd0), 0);
		wait_drained();
		@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (!paused && board.requests >= PAUSE_AT) begin
				paused = 1'b1;
				wait_drained();
				@(posedge clk);
			end
			if (board.requests >= HOLD_AT && board.requests < HOLD_AT + 64) begin
				gap = 0;
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(1, 8);
			end else begin
				burst_left--;
				gap = 0;
			end
			send(random_req(), gap);
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d results; ok %0d, bad index %0d, full %0d,",
			board.requests, board.responses, board.status_seen[STATUS_OK],
			board.status_seen[STATUS_RANGE], board.status_seen[STATUS_FULL]);
		$display("not found %0d, with one long receiver hold-off and one sender pause",
			board.status_seen[STATUS_NOTFOUND]);
		if (board.errors == 0 && board.expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* ordered_list_insert_remove.f */
hw/rtl/oli_pkg.sv
hw/rtl/oli_cell.sv
hw/rtl/ordered_list_insert_remove.sv
dv/list_check_pkg.sv
dv/testbench.sv
